### sv/fbld_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and helpers of the framebuffer line drawer.
package fbld_pkg;

    localparam int COLUMNS    = 128;
    localparam int PAGES      = 8;
    localparam int DEPTH      = COLUMNS * PAGES;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int X_W        = 7;
    localparam int Y_W        = 6;
    localparam int BYTE_W     = 8;
    localparam int PAGE_SHIFT = 3;
    localparam int ERR_W      = X_W + 1;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [X_W-1:0]    t_x;
    typedef logic [Y_W-1:0]    t_y;
    typedef logic [BYTE_W-1:0] t_byte;

    typedef enum logic [1:0] {
        KIND_CLEAR = 2'd0,
        KIND_POINT = 2'd1,
        KIND_LINE  = 2'd2,
        KIND_READ  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_PT_RD,
        ST_PT_WR,
        ST_RD_ADDR,
        ST_RD_DATA,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic advance;
        t_x   start_x;
        t_y   start_y;
        t_x   end_x;
        t_y   end_y;
    } t_step_ctl;

    typedef struct packed {
        t_x   x;
        t_y   y;
        logic last;
    } t_step_sts;

    function automatic logic fbld_in_store(input t_x x, input t_y y);
        return (int'(x) < COLUMNS) && (int'(y >> PAGE_SHIFT) < PAGES);
    endfunction

    function automatic t_addr fbld_index(input t_x x, input t_y y);
        return t_addr'(int'(x) * PAGES + int'(y >> PAGE_SHIFT));
    endfunction

endpackage

### sv/fbld_ifs.sv
`timescale 1ns / 1ps
// Command and response channel interfaces of the framebuffer line drawer.
interface fbld_cmd_if import fbld_pkg::*; ();
    logic  valid;
    logic  ready;
    t_kind kind;
    t_x    start_x;
    t_y    start_y;
    t_x    end_x;
    t_y    end_y;
    logic  pixel_value;

    modport source (output valid, kind, start_x, start_y, end_x, end_y, pixel_value,
                    input ready);
    modport sink (input valid, kind, start_x, start_y, end_x, end_y, pixel_value,
                  output ready);
endinterface

interface fbld_rsp_if import fbld_pkg::*; ();
    logic  valid;
    logic  ready;
    t_byte read_byte;

    modport source (output valid, read_byte, input ready);
    modport sink (input valid, read_byte, output ready);
endinterface

### sv/fbld_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM with registered read.
module fbld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### sv/fbld_stepper.sv
`timescale 1ns / 1ps
// Error-accumulator line stepper: current point and per-axis error registers.
module fbld_stepper import fbld_pkg::*; (
    input  logic      i_clk,
    input  t_step_ctl i_ctl,
    output t_step_sts o_sts
);
    t_x               r_cx;
    t_y               r_cy;
    logic [X_W-1:0]   r_ax;
    logic [Y_W-1:0]   r_ay;
    logic [X_W-1:0]   r_dist;
    logic [X_W-1:0]   r_n;
    logic [ERR_W-1:0] r_ex;
    logic [ERR_W-1:0] r_ey;
    logic             r_x_dec;
    logic             r_y_dec;

    logic [X_W-1:0]   n_ax;
    logic [Y_W-1:0]   n_ay;
    logic [ERR_W-1:0] ex_sum;
    logic [ERR_W-1:0] ey_sum;
    logic [ERR_W-1:0] dist_ext;

    always_comb begin
        n_ax = (i_ctl.end_x >= i_ctl.start_x) ? i_ctl.end_x - i_ctl.start_x
                                              : i_ctl.start_x - i_ctl.end_x;
        n_ay = (i_ctl.end_y >= i_ctl.start_y) ? i_ctl.end_y - i_ctl.start_y
                                              : i_ctl.start_y - i_ctl.end_y;
        ex_sum   = r_ex + ERR_W'(r_ax);
        ey_sum   = r_ey + ERR_W'(r_ay);
        dist_ext = ERR_W'(r_dist);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cx    <= i_ctl.start_x;
            r_cy    <= i_ctl.start_y;
            r_ax    <= n_ax;
            r_ay    <= n_ay;
            r_dist  <= (n_ax > X_W'(n_ay)) ? n_ax : X_W'(n_ay);
            r_x_dec <= i_ctl.end_x < i_ctl.start_x;
            r_y_dec <= i_ctl.end_y < i_ctl.start_y;
            r_n     <= '0;
            r_ex    <= '0;
            r_ey    <= '0;
        end else if (i_ctl.advance) begin
            r_n <= r_n + X_W'(1);
            if (ex_sum > dist_ext) begin
                r_ex <= ex_sum - dist_ext;
                r_cx <= r_x_dec ? r_cx - X_W'(1) : r_cx + X_W'(1);
            end else begin
                r_ex <= ex_sum;
            end
            if (ey_sum > dist_ext) begin
                r_ey <= ey_sum - dist_ext;
                r_cy <= r_y_dec ? r_cy - Y_W'(1) : r_cy + Y_W'(1);
            end else begin
                r_ey <= ey_sum;
            end
        end
    end

    assign o_sts.x    = r_cx;
    assign o_sts.y    = r_cy;
    assign o_sts.last = (r_n == r_dist);
endmodule

### sv/framebuffer_line_drawer.sv
`timescale 1ns / 1ps
// Framebuffer line drawer top level: command sequencer around the frame store.
// The frame store is a 1024-byte single memory (column-major, 8 page bytes per
// column); a point or line reaches it by read-modify-write, a clear only writes
// and a read only reads, one access at a time. After reset the block sweeps
// the store to zero and takes no command until that is done. A line steps
// through a read state and then a write state for each pixel. Every command
// returns one word; read_byte is zero except for a read inside the store. A
// new command is taken while the last result still waits at the output.
module framebuffer_line_drawer import fbld_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    fbld_cmd_if.sink        i_cmd,
    fbld_rsp_if.source      o_rsp
);
    t_state    r_state, n_state;
    t_addr     r_clr_addr;
    logic      r_val;
    t_x        r_rx;
    t_y        r_ry;
    t_byte     r_res;
    logic      r_out_valid;
    t_byte     r_out_byte;

    t_step_ctl step_ctl;
    t_step_sts step_sts;

    logic      accept;
    logic      load_out;
    logic      clr_last;
    logic      pt_in;
    logic      rd_in;
    logic      ram_we;
    t_addr     ram_waddr;
    t_byte     ram_wdata;
    t_addr     ram_raddr;
    t_byte     ram_rdata;
    t_byte     pix_mask;

    fbld_ram #(.WIDTH(BYTE_W), .DEPTH(DEPTH)) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    fbld_stepper u_stepper (
        .i_clk (i_clk),
        .i_ctl (step_ctl),
        .o_sts (step_sts)
    );

    assign accept   = i_cmd.valid && i_cmd.ready;
    assign clr_last = (r_clr_addr == t_addr'(DEPTH - 1));
    assign pt_in    = fbld_in_store(step_sts.x, step_sts.y);
    assign rd_in    = fbld_in_store(r_rx, r_ry);
    assign pix_mask = t_byte'(1) << step_sts.y[PAGE_SHIFT-1:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_INIT: begin
                if (clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_cmd.valid) begin
                    unique case (i_cmd.kind)
                        KIND_CLEAR: n_state = ST_CLEAR;
                        KIND_POINT, KIND_LINE: n_state = ST_PT_RD;
                        KIND_READ: n_state = ST_RD_ADDR;
                    endcase
                end
            end
            ST_CLEAR: begin
                if (clr_last) n_state = ST_DONE;
            end
            ST_PT_RD:   n_state = ST_PT_WR;
            ST_PT_WR: begin
                n_state = step_sts.last ? ST_DONE : ST_PT_RD;
            end
            ST_RD_ADDR: n_state = ST_RD_DATA;
            ST_RD_DATA: n_state = ST_DONE;
            ST_DONE: begin
                if (!r_out_valid || o_rsp.ready) n_state = ST_IDLE;
            end
            default:    n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        i_cmd.ready      = 1'b0;
        load_out         = 1'b0;
        ram_we           = 1'b0;
        ram_waddr        = r_clr_addr;
        ram_wdata        = '0;
        ram_raddr        = fbld_index(step_sts.x, step_sts.y);
        step_ctl.load    = 1'b0;
        step_ctl.advance = 1'b0;
        step_ctl.start_x = i_cmd.start_x;
        step_ctl.start_y = i_cmd.start_y;
        step_ctl.end_x   = (i_cmd.kind == KIND_LINE) ? i_cmd.end_x : i_cmd.start_x;
        step_ctl.end_y   = (i_cmd.kind == KIND_LINE) ? i_cmd.end_y : i_cmd.start_y;
        unique case (r_state)
            ST_INIT, ST_CLEAR: begin
                ram_we = 1'b1;
            end
            ST_IDLE: begin
                i_cmd.ready   = 1'b1;
                step_ctl.load = i_cmd.valid;
            end
            ST_PT_WR: begin
                ram_we           = pt_in;
                ram_waddr        = fbld_index(step_sts.x, step_sts.y);
                ram_wdata        = r_val ? (ram_rdata | pix_mask) : (ram_rdata & ~pix_mask);
                step_ctl.advance = !step_sts.last;
            end
            ST_RD_ADDR: begin
                ram_raddr = fbld_index(r_rx, r_ry);
            end
            ST_DONE: begin
                load_out = !r_out_valid || o_rsp.ready;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_INIT || r_state == ST_CLEAR) begin
                r_clr_addr <= clr_last ? '0 : r_clr_addr + t_addr'(1);
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_val <= i_cmd.pixel_value;
            r_rx  <= i_cmd.start_x;
            r_ry  <= i_cmd.start_y;
            r_res <= '0;
        end else if (r_state == ST_RD_DATA) begin
            r_res <= rd_in ? ram_rdata : '0;
        end
        if (load_out) begin
            r_out_byte <= r_res;
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.read_byte = r_out_byte;
endmodule
